[rtl/vau_pkg.sv]
package vau_pkg;

   localparam int VAU_FRAC_BITS    = 16;
   localparam int VAU_CORDIC_STEPS = 20;

   localparam logic [3:0] OP_ADD    = 4'd0;
   localparam logic [3:0] OP_SUB    = 4'd1;
   localparam logic [3:0] OP_MUL    = 4'd2;
   localparam logic [3:0] OP_SCALE  = 4'd3;
   localparam logic [3:0] OP_DIV    = 4'd4;
   localparam logic [3:0] OP_LENGTH = 4'd5;
   localparam logic [3:0] OP_NORM   = 4'd6;
   localparam logic [3:0] OP_TRUNC  = 4'd7;
   localparam logic [3:0] OP_SETMAG = 4'd8;
   localparam logic [3:0] OP_SETANG = 4'd9;

   // Q30 angle constants
   localparam logic [63:0] Q30_TWO_PI      = 64'd6746518852;
   localparam logic [63:0] Q30_PI          = 64'd3373259426;
   localparam logic [63:0] Q30_HALF_PI     = 64'd1686629713;
   localparam logic [63:0] Q30_CORDIC_GAIN = 64'd652032874;

   localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;
   localparam logic signed [67:0] SAT_HI  = 68'sd2147483647;
   localparam logic signed [67:0] SAT_LO  = -68'sd2147483648;

   typedef struct packed {
      logic [3:0]         opcode;
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] bx;
      logic signed [31:0] by;
      logic signed [31:0] scalar;
      logic signed [31:0] angle;
   } vau_req_type;

   typedef struct packed {
      logic signed [31:0] rx;
      logic signed [31:0] ry;
      logic [31:0]        magnitude;
      logic               div_zero;
   } vau_rsp_type;

   // one component's worth of operands for a lane
   typedef struct packed {
      logic [3:0]         opcode;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] scalar;
      logic [31:0]        len;
      logic signed [31:0] cs;
   } vau_lane_in_type;

   function automatic logic [31:0] atan_q30(input logic [4:0] idx);
      logic [31:0] res;
      unique case (idx)
         5'd0:  res = 32'd843314856;
         5'd1:  res = 32'd497837829;
         5'd2:  res = 32'd263043836;
         5'd3:  res = 32'd133525158;
         5'd4:  res = 32'd67021686;
         5'd5:  res = 32'd33543515;
         5'd6:  res = 32'd16775850;
         5'd7:  res = 32'd8388437;
         5'd8:  res = 32'd4194282;
         5'd9:  res = 32'd2097149;
         5'd10: res = 32'd1048575;
         5'd11: res = 32'd524287;
         5'd12: res = 32'd262143;
         5'd13: res = 32'd131071;
         5'd14: res = 32'd65535;
         5'd15: res = 32'd32767;
         5'd16: res = 32'd16383;
         5'd17: res = 32'd8191;
         5'd18: res = 32'd4095;
         5'd19: res = 32'd2047;
         5'd20: res = 32'd1023;
         5'd21: res = 32'd511;
         5'd22: res = 32'd255;
         5'd23: res = 32'd127;
         5'd24: res = 32'd63;
         5'd25: res = 32'd31;
         5'd26: res = 32'd15;
         5'd27: res = 32'd7;
         5'd28: res = 32'd3;
         5'd29: res = 32'd1;
         default: res = 32'd0;
      endcase
      return res;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      logic signed [31:0] res;
      if (v > SAT_HI) begin
         res = SAT_MAX;
      end else if (v < SAT_LO) begin
         res = SAT_MIN;
      end else begin
         res = v[31:0];
      end
      return res;
   endfunction

endpackage

[rtl/vau_angle.sv]
module vau_angle #(
   parameter int FRAC_BITS    = vau_pkg::VAU_FRAC_BITS,
   parameter int CORDIC_STEPS = vau_pkg::VAU_CORDIC_STEPS,
   parameter int SIDE_W       = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic signed [31:0]  angle,
   input  logic [SIDE_W-1:0]   side_i,
   output logic signed [31:0]  cos_o,
   output logic signed [31:0]  sin_o,
   output logic [SIDE_W-1:0]   side_o
);
   import vau_pkg::*;

   localparam int SH = 30 - FRAC_BITS;
   localparam int ZW = 32 + SH;
   localparam int KS = ZW - 33;

   localparam logic signed [34:0] PI35   = 35'(Q30_PI);
   localparam logic signed [34:0] TPI35  = 35'(Q30_TWO_PI);
   localparam logic signed [34:0] HPI35  = 35'(Q30_HALF_PI);
   localparam logic signed [33:0] GAIN34 = 34'(Q30_CORDIC_GAIN);

   typedef struct packed {
      logic              neg;
      logic [ZW-1:0]     mag;
      logic [SIDE_W-1:0] side;
   } red_type;

   typedef struct packed {
      logic               flip;
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [34:0] z;
      logic [SIDE_W-1:0]  side;
   } cor_type;

   red_type red_ff [KS+1];
   cor_type cor_ff [CORDIC_STEPS+1];

   // entry: magnitude of the angle, scaled to Q30
   red_type     red_first_in;
   logic [31:0] abs_a;
   always_comb begin
      abs_a              = angle[31] ? (~angle + 32'd1) : angle;
      red_first_in.neg   = angle[31];
      red_first_in.mag   = {abs_a, {SH{1'b0}}};
      red_first_in.side  = side_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_ff[0].side <= '0;
      end else if (en) begin
         red_ff[0] <= red_first_in;
      end
   end

   // restoring reduction modulo two pi, one multiple per stage
   for (genvar k = 0; k < KS; k++) begin : g_red
      localparam logic [ZW-1:0] STEP = ZW'(Q30_TWO_PI << (KS - 1 - k));
      red_type red_in;
      always_comb begin
         red_in = red_ff[k];
         if (red_ff[k].mag >= STEP) begin
            red_in.mag = red_ff[k].mag - STEP;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            red_ff[k+1].side <= '0;
         end else if (en) begin
            red_ff[k+1] <= red_in;
         end
      end
   end

   // fold into [-pi/2, pi/2]
   cor_type            fold_in;
   logic signed [34:0] z0;
   logic signed [34:0] z1;
   always_comb begin
      z0 = $signed({1'b0, red_ff[KS].mag[33:0]});
      if (red_ff[KS].neg) begin
         z0 = -z0;
      end
      z1 = z0;
      if (z0 > PI35) begin
         z1 = z0 - TPI35;
      end else if (z0 < -PI35) begin
         z1 = z0 + TPI35;
      end
      fold_in.flip = 1'b0;
      fold_in.z    = z1;
      if (z1 > HPI35) begin
         fold_in.z    = z1 - PI35;
         fold_in.flip = 1'b1;
      end else if (z1 < -HPI35) begin
         fold_in.z    = z1 + PI35;
         fold_in.flip = 1'b1;
      end
      fold_in.x    = GAIN34;
      fold_in.y    = '0;
      fold_in.side = red_ff[KS].side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cor_ff[0].side <= '0;
      end else if (en) begin
         cor_ff[0] <= fold_in;
      end
   end

   // one rotation per stage
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cor
      localparam logic signed [34:0] ATAN = 35'(atan_q30(5'(i)));
      cor_type            step_in;
      logic signed [33:0] xs;
      logic signed [33:0] ys;
      always_comb begin
         xs      = cor_ff[i].x >>> i;
         ys      = cor_ff[i].y >>> i;
         step_in = cor_ff[i];
         if (!cor_ff[i].z[34]) begin
            step_in.x = cor_ff[i].x - ys;
            step_in.y = cor_ff[i].y + xs;
            step_in.z = cor_ff[i].z - ATAN;
         end else begin
            step_in.x = cor_ff[i].x + ys;
            step_in.y = cor_ff[i].y - xs;
            step_in.z = cor_ff[i].z + ATAN;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            cor_ff[i+1].side <= '0;
         end else if (en) begin
            cor_ff[i+1] <= step_in;
         end
      end
   end

   logic signed [33:0] cx;
   logic signed [33:0] sy;
   always_comb begin
      cx     = cor_ff[CORDIC_STEPS].flip ? -cor_ff[CORDIC_STEPS].x : cor_ff[CORDIC_STEPS].x;
      sy     = cor_ff[CORDIC_STEPS].flip ? -cor_ff[CORDIC_STEPS].y : cor_ff[CORDIC_STEPS].y;
      cos_o  = cx[31:0];
      sin_o  = sy[31:0];
      side_o = cor_ff[CORDIC_STEPS].side;
   end

endmodule

[rtl/vau_isqrt.sv]
module vau_isqrt #(
   parameter int SIDE_W = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic signed [31:0] ax,
   input  logic signed [31:0] ay,
   input  logic [SIDE_W-1:0]  side_i,
   output logic [31:0]        root_o,
   output logic [SIDE_W-1:0]  side_o
);
   import vau_pkg::*;

   localparam int STEPS = 32;

   typedef struct packed {
      logic [63:0]       px;
      logic [63:0]       py;
      logic [SIDE_W-1:0] side;
   } sq_type;

   typedef struct packed {
      logic [63:0]       rem;
      logic [63:0]       root;
      logic [SIDE_W-1:0] side;
   } rt_type;

   sq_type sq_ff;
   rt_type rt_ff [STEPS+1];

   // squares
   sq_type             sq_in;
   logic signed [63:0] ax_w;
   logic signed [63:0] ay_w;
   always_comb begin
      ax_w       = 64'(ax);
      ay_w       = 64'(ay);
      sq_in.px   = ax_w * ax_w;
      sq_in.py   = ay_w * ay_w;
      sq_in.side = side_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff.side <= '0;
      end else if (en) begin
         sq_ff <= sq_in;
      end
   end

   // sum of squares seeds the root search
   rt_type sum_in;
   always_comb begin
      sum_in.rem  = sq_ff.px + sq_ff.py;
      sum_in.root = '0;
      sum_in.side = sq_ff.side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rt_ff[0].side <= '0;
      end else if (en) begin
         rt_ff[0] <= sum_in;
      end
   end

   // one result bit per stage
   for (genvar k = 0; k < STEPS; k++) begin : g_rt
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      rt_type      rt_in;
      logic [63:0] trial;
      always_comb begin
         trial = rt_ff[k].root + BIT;
         rt_in = rt_ff[k];
         if (rt_ff[k].rem >= trial) begin
            rt_in.rem  = rt_ff[k].rem - trial;
            rt_in.root = (rt_ff[k].root >> 1) + BIT;
         end else begin
            rt_in.root = rt_ff[k].root >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            rt_ff[k+1].side <= '0;
         end else if (en) begin
            rt_ff[k+1] <= rt_in;
         end
      end
   end

   assign root_o = rt_ff[STEPS].root[31:0];
   assign side_o = rt_ff[STEPS].side;

endmodule

[rtl/vau_lane.sv]
module vau_lane #(
   parameter int FRAC_BITS = vau_pkg::VAU_FRAC_BITS,
   parameter int SIDE_W    = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  vau_pkg::vau_lane_in_type  lane_i,
   input  logic [SIDE_W-1:0]         side_i,
   output logic signed [31:0]        r_o,
   output logic [SIDE_W-1:0]         side_o
);
   import vau_pkg::*;

   localparam int QW = 32 + FRAC_BITS;

   typedef struct packed {
      vau_lane_in_type   li;
      logic [31:0]       d;
      logic              neg;
      logic              zero;
      logic [QW-1:0]     nq;
      logic [32:0]       rem;
      logic [SIDE_W-1:0] side;
   } dv_type;

   typedef struct packed {
      vau_lane_in_type    li;
      logic signed [31:0] n;
      logic [SIDE_W-1:0]  side;
   } nv_type;

   typedef struct packed {
      vau_lane_in_type    li;
      logic signed [31:0] n;
      logic signed [65:0] p;
      logic [SIDE_W-1:0]  side;
   } mp_type;

   dv_type             dv_ff [QW+1];
   nv_type             nv_ff;
   mp_type             mp_ff;
   logic signed [31:0] r_ff;
   logic [SIDE_W-1:0]  side_ff;

   // divisor is the scalar for divide, the length otherwise
   dv_type      dv_first_in;
   logic        div_op;
   logic [31:0] abs_a;
   logic [31:0] abs_s;
   always_comb begin
      div_op           = (lane_i.opcode == OP_DIV);
      abs_a            = lane_i.a[31] ? (~lane_i.a + 32'd1) : lane_i.a;
      abs_s            = lane_i.scalar[31] ? (~lane_i.scalar + 32'd1) : lane_i.scalar;
      dv_first_in.li   = lane_i;
      dv_first_in.d    = div_op ? abs_s : lane_i.len;
      dv_first_in.neg  = div_op ? (lane_i.a[31] ^ lane_i.scalar[31]) : lane_i.a[31];
      dv_first_in.zero = div_op ? (lane_i.scalar == '0) : (lane_i.len == '0);
      dv_first_in.nq   = {abs_a, {FRAC_BITS{1'b0}}};
      dv_first_in.rem  = '0;
      dv_first_in.side = side_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0].side <= '0;
      end else if (en) begin
         dv_ff[0] <= dv_first_in;
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar j = 0; j < QW; j++) begin : g_div
      dv_type      dv_in;
      logic [32:0] t;
      logic        qbit;
      always_comb begin
         t     = {dv_ff[j].rem[31:0], dv_ff[j].nq[QW-1]};
         qbit  = (t >= {1'b0, dv_ff[j].d});
         dv_in = dv_ff[j];
         dv_in.rem = qbit ? (t - {1'b0, dv_ff[j].d}) : t;
         dv_in.nq  = {dv_ff[j].nq[QW-2:0], qbit};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j+1].side <= '0;
         end else if (en) begin
            dv_ff[j+1] <= dv_in;
         end
      end
   end

   // signed, saturated quotient
   nv_type        nv_in;
   logic [QW-1:0] q;
   always_comb begin
      q        = dv_ff[QW].nq;
      nv_in.li   = dv_ff[QW].li;
      nv_in.side = dv_ff[QW].side;
      if (dv_ff[QW].zero) begin
         if (dv_ff[QW].li.opcode == OP_DIV) begin
            if (dv_ff[QW].li.a[31]) begin
               nv_in.n = SAT_MIN;
            end else if (dv_ff[QW].li.a != '0) begin
               nv_in.n = SAT_MAX;
            end else begin
               nv_in.n = '0;
            end
         end else begin
            nv_in.n = dv_ff[QW].li.a;
         end
      end else if (!dv_ff[QW].neg) begin
         nv_in.n = (|q[QW-1:31]) ? SAT_MAX : q[31:0];
      end else if ((|q[QW-1:32]) || (q[31] && (|q[30:0]))) begin
         nv_in.n = SAT_MIN;
      end else begin
         nv_in.n = ~q[31:0] + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nv_ff.side <= '0;
      end else if (en) begin
         nv_ff <= nv_in;
      end
   end

   // shared multiplier
   mp_type             mp_in;
   logic signed [32:0] ma;
   logic signed [32:0] mb;
   always_comb begin
      unique case (nv_ff.li.opcode)
         OP_MUL: begin
            ma = 33'(nv_ff.li.a);
            mb = 33'(nv_ff.li.b);
         end
         OP_SCALE: begin
            ma = 33'(nv_ff.li.a);
            mb = 33'(nv_ff.li.scalar);
         end
         OP_SETANG: begin
            ma = 33'(nv_ff.li.cs);
            mb = $signed({1'b0, nv_ff.li.len});
         end
         default: begin
            ma = 33'(nv_ff.n);
            mb = 33'(nv_ff.li.scalar);
         end
      endcase
      mp_in.li   = nv_ff.li;
      mp_in.n    = nv_ff.n;
      mp_in.p    = ma * mb;
      mp_in.side = nv_ff.side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mp_ff.side <= '0;
      end else if (en) begin
         mp_ff <= mp_in;
      end
   end

   // select the component result
   logic signed [31:0] r_in;
   logic signed [65:0] sh;
   logic signed [31:0] msat;
   logic signed [32:0] s_add;
   logic signed [32:0] s_sub;
   logic               take;
   always_comb begin
      sh    = (mp_ff.li.opcode == OP_SETANG) ? (mp_ff.p >>> 30) : (mp_ff.p >>> FRAC_BITS);
      msat  = sat32(68'(sh));
      s_add = 33'(mp_ff.li.a) + 33'(mp_ff.li.b);
      s_sub = 33'(mp_ff.li.a) - 33'(mp_ff.li.b);
      take  = $signed({1'b0, mp_ff.li.len}) > 33'(mp_ff.li.scalar);
      unique case (mp_ff.li.opcode)
         OP_ADD:    r_in = sat32(68'(s_add));
         OP_SUB:    r_in = sat32(68'(s_sub));
         OP_MUL:    r_in = msat;
         OP_SCALE:  r_in = msat;
         OP_DIV:    r_in = mp_ff.n;
         OP_NORM:   r_in = mp_ff.n;
         OP_TRUNC:  r_in = take ? msat : mp_ff.li.a;
         OP_SETMAG: r_in = msat;
         OP_SETANG: r_in = msat;
         default:   r_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= '0;
      end else if (en) begin
         side_ff <= mp_ff.side;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff <= r_in;
      end
   end

   assign r_o    = r_ff;
   assign side_o = side_ff;

endmodule

[rtl/vector2d_arithmetic_unit.sv]
// Two-dimensional vector arithmetic unit, signed fixed point (Q16.16 by default).
//
// Channels: req_* carries one item (opcode, vectors a and b, scalar, angle);
// rsp_* returns one item per request (rx, ry, magnitude of a, div_zero).
// Both use valid/ready; an item moves on a clock edge where both are high.
//
// Throughput: one item per cycle while the receiver does not stall the output.
// From acceptance to rsp_valid, an item passes the angle reduction and CORDIC
// stages, the 32-stage square root, the 32 + FRAC_BITS stage divider in each
// lane, and the multiply, select and output registers. Results come out in
// request order.
//
// Reset clears every valid flag in the pipeline and the output register; no
// item is in flight afterward. When the receiver holds rsp_ready low while a
// result waits, the whole pipeline freezes in place and req_ready drops, so
// nothing is lost or repeated; it resumes as soon as the result is taken.
module vector2d_arithmetic_unit #(
   parameter int FRAC_BITS    = vau_pkg::VAU_FRAC_BITS,
   parameter int CORDIC_STEPS = vau_pkg::VAU_CORDIC_STEPS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  vau_pkg::vau_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output vau_pkg::vau_rsp_type rsp_data
);
   import vau_pkg::*;

   typedef struct packed {
      logic        valid;
      vau_req_type req;
   } a_side_type;

   typedef struct packed {
      a_side_type         a;
      logic signed [31:0] cos_q;
      logic signed [31:0] sin_q;
   } s_side_type;

   typedef struct packed {
      logic        valid;
      logic        dz;
      logic [31:0] len;
   } x_side_type;

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   vau_rsp_type rsp_data_ff;
   vau_rsp_type rsp_data_in;

   // advance everything whenever the output slot is free or being emptied
   logic en;
   assign en        = ~rsp_valid_ff | rsp_ready;
   assign req_ready = en;

   a_side_type         a_side_in;
   a_side_type         a_side_out;
   logic signed [31:0] cos_q;
   logic signed [31:0] sin_q;

   assign a_side_in.valid = req_valid;
   assign a_side_in.req   = req_data;

   vau_angle #(
      .FRAC_BITS    (FRAC_BITS),
      .CORDIC_STEPS (CORDIC_STEPS),
      .SIDE_W       ($bits(a_side_type))
   ) u_angle (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .angle  (req_data.angle),
      .side_i (a_side_in),
      .cos_o  (cos_q),
      .sin_o  (sin_q),
      .side_o (a_side_out)
   );

   s_side_type  s_side_in;
   s_side_type  s_side_out;
   logic [31:0] len;

   assign s_side_in.a     = a_side_out;
   assign s_side_in.cos_q = cos_q;
   assign s_side_in.sin_q = sin_q;

   vau_isqrt #(
      .SIDE_W ($bits(s_side_type))
   ) u_isqrt (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .ax     (a_side_out.req.ax),
      .ay     (a_side_out.req.ay),
      .side_i (s_side_in),
      .root_o (len),
      .side_o (s_side_out)
   );

   // x and y lanes run side by side
   vau_lane_in_type    x_lane_in;
   vau_lane_in_type    y_lane_in;
   x_side_type         x_side_in;
   x_side_type         x_side_out;
   logic               y_valid_out;
   logic signed [31:0] rx;
   logic signed [31:0] ry;

   always_comb begin
      x_lane_in.opcode = s_side_out.a.req.opcode;
      x_lane_in.a      = s_side_out.a.req.ax;
      x_lane_in.b      = s_side_out.a.req.bx;
      x_lane_in.scalar = s_side_out.a.req.scalar;
      x_lane_in.len    = len;
      x_lane_in.cs     = s_side_out.cos_q;

      y_lane_in.opcode = s_side_out.a.req.opcode;
      y_lane_in.a      = s_side_out.a.req.ay;
      y_lane_in.b      = s_side_out.a.req.by;
      y_lane_in.scalar = s_side_out.a.req.scalar;
      y_lane_in.len    = len;
      y_lane_in.cs     = s_side_out.sin_q;

      x_side_in.valid  = s_side_out.a.valid;
      x_side_in.dz     = (s_side_out.a.req.opcode == OP_DIV) &&
                         (s_side_out.a.req.scalar == '0);
      x_side_in.len    = len;
   end

   vau_lane #(
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    ($bits(x_side_type))
   ) u_lane_x (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .lane_i (x_lane_in),
      .side_i (x_side_in),
      .r_o    (rx),
      .side_o (x_side_out)
   );

   vau_lane #(
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    (1)
   ) u_lane_y (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .lane_i (y_lane_in),
      .side_i (s_side_out.a.valid),
      .r_o    (ry),
      .side_o (y_valid_out)
   );

   // merge the lanes into the output register
   always_comb begin
      rsp_valid_in          = x_side_out.valid & y_valid_out;
      rsp_data_in.rx        = rx;
      rsp_data_in.ry        = ry;
      rsp_data_in.magnitude = x_side_out.len;
      rsp_data_in.div_zero  = x_side_out.dz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the payload while the receiver stalls
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[test/vector2d_arithmetic_unit_checker.sv]
module vector2d_arithmetic_unit_checker
   import vau_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  vau_req_type req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  vau_rsp_type rsp_data,
   output int          fail_count,
   output int          outstanding
);

   localparam longint TWO_PI_Q30  = longint'(Q30_TWO_PI);
   localparam longint PI_Q30      = longint'(Q30_PI);
   localparam longint HALF_PI_Q30 = longint'(Q30_HALF_PI);
   localparam longint GAIN_Q30    = longint'(Q30_CORDIC_GAIN);
   localparam longint ONE_Q       = longint'(1) << VAU_FRAC_BITS;

   localparam longint ARCTAN_Q30 [32] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
      65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
      15, 7, 3, 1, 0, 0};

   vau_rsp_type expected_results[$];

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fff_ffff;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned rem, root, bitpos;
      rem = v;
      root = 0;
      bitpos = 64'd1 << 62;
      while (bitpos != 0) begin
         if (rem >= root + bitpos) begin
            rem = rem - (root + bitpos);
            root = (root >> 1) + bitpos;
         end else begin
            root = root >> 1;
         end
         bitpos = bitpos >> 2;
      end
      return root;
   endfunction

   // unit vector, zero length leaves the vector as it is
   function automatic void unit_dir(input longint x, input longint y, input longint len,
                                    output longint ox, output longint oy);
      if (len == 0) begin
         ox = x;
         oy = y;
      end else begin
         ox = clamp32((x * ONE_Q) / len);
         oy = clamp32((y * ONE_Q) / len);
      end
   endfunction

   function automatic void resize(input longint x, input longint y, input longint len,
                                  input longint s, output longint ox, output longint oy);
      longint nx, ny;
      unit_dir(x, y, len, nx, ny);
      ox = clamp32((nx * s) >>> VAU_FRAC_BITS);
      oy = clamp32((ny * s) >>> VAU_FRAC_BITS);
   endfunction

   function automatic longint quotient(input longint a, input longint d);
      if (d == 0) return (a > 0) ? 64'sd2147483647 : ((a < 0) ? -64'sd2147483648 : 0);
      return clamp32((a * ONE_Q) / d);
   endfunction

   function automatic void rotate_unit(input longint ang, output longint c, output longint s);
      longint z, x, y, xs, ys;
      bit flip;
      z = (ang * (longint'(1) << (30 - VAU_FRAC_BITS))) % TWO_PI_Q30;
      x = GAIN_Q30;
      y = 0;
      flip = 0;
      if (z > PI_Q30) z = z - TWO_PI_Q30;
      else if (z < -PI_Q30) z = z + TWO_PI_Q30;
      if (z > HALF_PI_Q30) begin
         z = z - PI_Q30;
         flip = 1;
      end else if (z < -HALF_PI_Q30) begin
         z = z + PI_Q30;
         flip = 1;
      end
      for (int i = 0; i < VAU_CORDIC_STEPS && i < 32; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - ARCTAN_Q30[i];
         end else begin
            x = x + ys; y = y - xs; z = z + ARCTAN_Q30[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic vau_rsp_type compute_vector_result(input vau_req_type r);
      vau_rsp_type res;
      longint ax, ay, bx, by, sc, len, rx, ry, c, s;
      longint unsigned sq;
      ax = r.ax; ay = r.ay; bx = r.bx; by = r.by; sc = r.scalar;
      sq = longint'(ax * ax) + longint'(ay * ay);
      len = longint'(int_sqrt(sq));
      rx = 0;
      ry = 0;
      res.div_zero = 1'b0;
      case (r.opcode)
         OP_ADD: begin
            rx = clamp32(ax + bx); ry = clamp32(ay + by);
         end
         OP_SUB: begin
            rx = clamp32(ax - bx); ry = clamp32(ay - by);
         end
         OP_MUL: begin
            rx = clamp32((ax * bx) >>> VAU_FRAC_BITS);
            ry = clamp32((ay * by) >>> VAU_FRAC_BITS);
         end
         OP_SCALE: begin
            rx = clamp32((ax * sc) >>> VAU_FRAC_BITS);
            ry = clamp32((ay * sc) >>> VAU_FRAC_BITS);
         end
         OP_DIV: begin
            res.div_zero = (sc == 0);
            rx = quotient(ax, sc);
            ry = quotient(ay, sc);
         end
         OP_NORM: unit_dir(ax, ay, len, rx, ry);
         OP_TRUNC: begin
            if (len > sc) resize(ax, ay, len, sc, rx, ry);
            else begin
               rx = ax; ry = ay;
            end
         end
         OP_SETMAG: resize(ax, ay, len, sc, rx, ry);
         OP_SETANG: begin
            rotate_unit(longint'(r.angle), c, s);
            rx = clamp32((c * len) >>> 30);
            ry = clamp32((s * len) >>> 30);
         end
         default: ;
      endcase
      res.rx = rx[31:0];
      res.ry = ry[31:0];
      res.magnitude = len[31:0];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      vau_rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) expected_results.push_back(compute_vector_result(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected item", rsp_data.rx, 32'd0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.rx !== want.rx) report_mismatch("rx", rsp_data.rx, want.rx);
               if (rsp_data.ry !== want.ry) report_mismatch("ry", rsp_data.ry, want.ry);
               if (rsp_data.magnitude !== want.magnitude)
                  report_mismatch("magnitude", rsp_data.magnitude, want.magnitude);
               if (rsp_data.div_zero !== want.div_zero)
                  report_mismatch("div_zero", {31'd0, rsp_data.div_zero},
                                  {31'd0, want.div_zero});
            end
         end
      end
      outstanding = expected_results.size();
   end

endmodule

[test/vector2d_arithmetic_unit_tb.sv]
module vector2d_arithmetic_unit_tb;
   import vau_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 200;
   localparam int HOLD_CYCLES    = 400;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   vau_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   vau_rsp_type rsp_data;
   int          fail_count;
   int          outstanding;

   // idle percentages for the current phase
   int send_idle_pct;
   int recv_stall_pct;
   bit hold_request;
   int hold_left;
   int quiet_cycles;

   vector2d_arithmetic_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   vector2d_arithmetic_unit_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: random stalls, plus one long hold-off that backs up the pipe.
   initial begin
      rsp_ready = 1'b0;
      hold_left = -1;
   end
   always @(posedge clock) begin
      if (hold_request && hold_left < 0) begin
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: count cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // Offer one item; drop valid for idle cycles first, then hold until taken.
   task automatic send_item(input vau_req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(5))
         0, 1:    return $urandom;
         2:       return $urandom_range(32'h0040_0000) - 32'h0020_0000;
         3:       return $urandom_range(32'h0400_0000) - 32'h0200_0000;
         4:       return {($urandom_range(1) != 0) ? 16'hffff : 16'h0000,
                          16'($urandom_range(16'hffff))};
         default: begin
            case ($urandom_range(3))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 32'h0;
               default: return 32'h0001_0000;
            endcase
         end
      endcase
   endfunction

   function automatic vau_req_type random_item();
      vau_req_type r;
      r.opcode = ($urandom_range(19) == 0) ? 4'($urandom_range(10, 15))
                                           : 4'($urandom_range(9));
      r.ax = pick_word();
      r.ay = pick_word();
      r.bx = pick_word();
      r.by = pick_word();
      r.scalar = ($urandom_range(9) == 0) ? 32'sd0 : pick_word();
      r.angle = pick_word();
      return r;
   endfunction

   function automatic vau_req_type make_item(input logic [3:0] op, input logic [31:0] ax,
                                             input logic [31:0] ay, input logic [31:0] bx,
                                             input logic [31:0] by, input logic [31:0] sc,
                                             input logic [31:0] an);
      vau_req_type r;
      r.opcode = op; r.ax = ax; r.ay = ay; r.bx = bx; r.by = by;
      r.scalar = sc; r.angle = an;
      return r;
   endfunction

   initial begin
      vau_req_type directed_items[$];
      req_valid      = 1'b0;
      req_data       = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_request   = 1'b0;
      quiet_cycles   = 0;
      reset          = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: saturation, each operation, zero divisor and zero vector.
      directed_items.push_back(make_item(OP_ADD, 32'h7fffffff, 32'h80000000,
                                         32'h7fffffff, 32'h80000000, 0, 0));
      directed_items.push_back(make_item(OP_SUB, 32'h80000000, 32'h7fffffff,
                                         32'h7fffffff, 32'h80000000, 0, 0));
      directed_items.push_back(make_item(OP_MUL, 32'h7fffffff, 32'h80000000,
                                         32'h7fffffff, 32'h7fffffff, 0, 0));
      directed_items.push_back(make_item(OP_MUL, 32'hfffe8000, 32'h00018000,
                                         32'h00020000, 32'hffff0000, 0, 0));
      directed_items.push_back(make_item(OP_SCALE, 32'h00030000, 32'hfffd0000,
                                         0, 0, 32'hffff8000, 0));
      directed_items.push_back(make_item(OP_DIV, 32'h00050000, 32'hfffb0000,
                                         0, 0, 32'h0, 0));
      directed_items.push_back(make_item(OP_DIV, 32'h0, 32'h80000000, 0, 0, 32'h0, 0));
      directed_items.push_back(make_item(OP_DIV, 32'h7fffffff, 32'h80000000,
                                         0, 0, 32'h00000001, 0));
      directed_items.push_back(make_item(OP_DIV, 32'h00070000, 32'hfff90000,
                                         0, 0, 32'hfffe0000, 0));
      directed_items.push_back(make_item(OP_LENGTH, 32'h80000000, 32'h80000000, 0, 0, 0, 0));
      directed_items.push_back(make_item(OP_LENGTH, 32'h00030000, 32'h00040000, 0, 0, 0, 0));
      directed_items.push_back(make_item(OP_NORM, 32'h0, 32'h0, 0, 0, 0, 0));
      directed_items.push_back(make_item(OP_NORM, 32'h00030000, 32'hfffc0000, 0, 0, 0, 0));
      directed_items.push_back(make_item(OP_NORM, 32'h00000001, 32'h0, 0, 0, 0, 0));
      directed_items.push_back(make_item(OP_TRUNC, 32'h00030000, 32'h00040000,
                                         0, 0, 32'h00020000, 0));
      directed_items.push_back(make_item(OP_TRUNC, 32'h00030000, 32'h00040000,
                                         0, 0, 32'h000a0000, 0));
      directed_items.push_back(make_item(OP_TRUNC, 32'h00030000, 32'h00040000,
                                         0, 0, 32'hfffe0000, 0));
      directed_items.push_back(make_item(OP_SETMAG, 32'h0, 32'h0, 0, 0, 32'h00050000, 0));
      directed_items.push_back(make_item(OP_SETMAG, 32'h00010000, 32'h00010000,
                                         0, 0, 32'h7fffffff, 0));
      directed_items.push_back(make_item(OP_SETANG, 32'h00050000, 0, 0, 0, 0, 32'h0));
      directed_items.push_back(make_item(OP_SETANG, 32'h00050000, 0, 0, 0, 0, 32'h0003243f));
      directed_items.push_back(make_item(OP_SETANG, 32'h00050000, 0, 0, 0, 0, 32'hfffcdbc1));
      directed_items.push_back(make_item(OP_SETANG, 32'h7fffffff, 32'h7fffffff,
                                         0, 0, 0, 32'h7fffffff));
      directed_items.push_back(make_item(OP_SETANG, 32'h00020000, 0, 0, 0, 0, 32'h80000000));
      directed_items.push_back(make_item(4'd15, 32'h00030000, 32'h00040000,
                                         32'hffffffff, 32'hffffffff, 32'hffffffff,
                                         32'hffffffff));
      foreach (directed_items[i]) send_item(directed_items[i]);

      // Random phases: free flow, sender idle, receiver stall, both idle.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
         endcase
         for (int n = 0; n < 232; n++) begin
            // start the long receiver hold-off at item 40 of the free phase
            if (phase == 0 && n == 40) hold_request = 1'b1;
            send_item(random_item());
         end
      end
      req_valid <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[files.f]
rtl/vau_pkg.sv
rtl/vau_angle.sv
rtl/vau_isqrt.sv
rtl/vau_lane.sv
rtl/vector2d_arithmetic_unit.sv
test/vector2d_arithmetic_unit_checker.sv
test/vector2d_arithmetic_unit_tb.sv
